// File: design/fbrd_pkg.sv
`timescale 1ns / 1ps
package fbrd_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int CYCLE_W   = 32;
    localparam int TAG_W     = 16;
    localparam int REG_W     = 7;
    localparam int POOL_W    = 8;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RETURN  = 2'd1,
        OP_ISSUE   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DCHK,
        S_DRD,
        S_ISS2,
        S_OUT
    } state_t;

    localparam logic CFG_PIPE_DELAY   = 1'b0;
    localparam logic CFG_MAX_REQUESTS = 1'b1;

    typedef struct packed {
        logic fire;
        op_t  op;
        logic in_window;
        logic fifo_nonempty;
        logic mark_hit;
        logic out_free;
    } seq_status_t;

endpackage

// File: design/fetch_bucket_reorder_delay.sv
`timescale 1ns / 1ps
// Sequence: allocate, release and rejected return go from S_EXEC to S_OUT;
// try issue goes S_EXEC, S_ISS2, S_OUT (S_ISS2 skipped when the delay FIFO is empty); an in-window
// return goes S_EXEC, S_DCHK, then S_DRD and S_DCHK again per drained tag (reorder RAM read per tag), S_OUT.
// One item at a time: ready only while the sequencer idles.
// Reset (rst_n, async low) and any config write restart the tracker: tags and
// FIFO zero, credits = max_requests, pool = pipe_delay + 1 + max_requests.
module fetch_bucket_reorder_delay (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [fbrd_pkg::REG_W-1:0]        cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] bucket_seq, [16] bkt_empty, [48:17] current_cycle
    input  logic [fbrd_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] opcode
    input  logic [1:0]                        s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] alloc_granted, [16:1] alloc_seq, [17] issue_valid, [33:18] issue_seq,
    // [34] outstanding, [41:35] credits_free, [49:42] buckets_free
    output logic [fbrd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import fbrd_pkg::*;

    state_t      state;
    seq_status_t status;

    // configuration
    logic [REG_W-1:0]  pipe_delay_reg, max_req_reg;
    logic [POOL_W-1:0] pool_cap;

    // latched item
    op_t                op_reg;
    logic [TAG_W-1:0]   seq_reg;
    logic               empty_reg;
    logic [CYCLE_W-1:0] now_reg;

    // tracker state
    logic [TAG_W-1:0]  next_tag_reg, exp_tag_reg;
    logic [REG_W-1:0]  credit_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [SLOTS-1:0]  mark_reg;
    logic [CNT_W-1:0]  marks_set_reg;
    logic [CNT_W-1:0]  fifo_cnt_reg;
    logic [SLOT_W-1:0] head_reg, tail_reg;

    // per-item results
    logic             granted_reg, ivalid_reg;
    logic [TAG_W-1:0] aseq_reg, iseq_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // memories: reorder slot {empty, stamp}, delay FIFO {tag, stamp}
    logic                 rob_we, rob_re;
    logic [SLOT_W-1:0]    rob_raddr;
    logic [CYCLE_W:0]     rob_rdata;
    logic                 fifo_we, fifo_re;
    logic [TAG_W+CYCLE_W-1:0] fifo_rdata;

    logic [TAG_W-1:0]   win_off;
    logic               in_window;
    logic               drain_push;
    logic [CYCLE_W:0]   due_cycle;
    logic               head_ready;
    logic               out_free;
    logic               fire;
    logic               outstanding;

    assign s_tready   = (state == S_IDLE);
    assign fire       = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign pool_cap   = POOL_W'(pipe_delay_reg) + POOL_W'(1) + POOL_W'(max_req_reg);

    assign win_off    = seq_reg - exp_tag_reg;
    assign in_window  = (win_off[TAG_W-1:SLOT_W] == '0);

    assign rob_we     = (state == S_EXEC) && (op_reg == OP_RETURN) && in_window;
    assign rob_re     = (state == S_DCHK);
    assign rob_raddr  = exp_tag_reg[SLOT_W-1:0];

    // drained non-empty bucket goes into the delay FIFO unless it is full
    assign drain_push = (state == S_DRD) && !rob_rdata[CYCLE_W] &&
                        (fifo_cnt_reg < CNT_W'(SLOTS));
    assign fifo_we    = drain_push;
    assign fifo_re    = (state == S_EXEC) && (op_reg == OP_ISSUE);

    // stamp + pipe_delay <= now, in one extra bit so it never wraps
    assign due_cycle  = {1'b0, fifo_rdata[CYCLE_W-1:0]} + (CYCLE_W+1)'(pipe_delay_reg);
    assign head_ready = (due_cycle <= {1'b0, now_reg});

    assign outstanding = (fifo_cnt_reg != '0) || (marks_set_reg != '0) ||
                         (credit_reg < max_req_reg);

    always_comb
    begin
        status.fire          = fire;
        status.op            = op_reg;
        status.in_window     = in_window;
        status.fifo_nonempty = (fifo_cnt_reg != '0);
        status.mark_hit      = mark_reg[exp_tag_reg[SLOT_W-1:0]];
        status.out_free      = out_free;
    end

    fbrd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .state  (state)
    );

    fbrd_ram #(.WIDTH(CYCLE_W + 1), .DEPTH(SLOTS)) u_rob_ram (
        .clk   (clk),
        .we    (rob_we),
        .waddr (seq_reg[SLOT_W-1:0]),
        .wdata ({empty_reg, now_reg}),
        .re    (rob_re),
        .raddr (rob_raddr),
        .rdata (rob_rdata)
    );

    fbrd_ram #(.WIDTH(TAG_W + CYCLE_W), .DEPTH(SLOTS)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata ({exp_tag_reg, rob_rdata[CYCLE_W-1:0]}),
        .re    (fifo_re),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    // item capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            op_reg    <= op_t'(s_tuser);
            seq_reg   <= s_tdata[15:0];
            empty_reg <= s_tdata[16];
            now_reg   <= s_tdata[48:17];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_delay_reg <= REG_W'(2);
            max_req_reg    <= REG_W'(8);
            next_tag_reg   <= '0;
            exp_tag_reg    <= '0;
            credit_reg     <= REG_W'(8);
            pool_reg       <= POOL_W'(11);
            mark_reg       <= '0;
            marks_set_reg  <= '0;
            fifo_cnt_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            granted_reg    <= 1'b0;
            ivalid_reg     <= 1'b0;
            aseq_reg       <= '0;
            iseq_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else if (cfg_we)
        begin
            // restart with the new register value (to be written only when idle; the block does not enforce it)
            if (cfg_addr == CFG_PIPE_DELAY)
            begin
                pipe_delay_reg <= cfg_wdata;
                pool_reg       <= POOL_W'(cfg_wdata) + POOL_W'(1) + POOL_W'(max_req_reg);
                credit_reg     <= max_req_reg;
            end
            else
            begin
                max_req_reg <= cfg_wdata;
                pool_reg    <= POOL_W'(pipe_delay_reg) + POOL_W'(1) + POOL_W'(cfg_wdata);
                credit_reg  <= cfg_wdata;
            end
            next_tag_reg  <= '0;
            exp_tag_reg   <= '0;
            mark_reg      <= '0;
            marks_set_reg <= '0;
            fifo_cnt_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (m_tvalid && m_tready && (state != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state)
                S_IDLE:
                begin
                    granted_reg <= 1'b0;
                    ivalid_reg  <= 1'b0;
                    aseq_reg    <= '0;
                    iseq_reg    <= '0;
                end
                S_EXEC:
                begin
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if (credit_reg != '0 && pool_reg != '0)
                            begin
                                credit_reg   <= credit_reg - REG_W'(1);
                                pool_reg     <= pool_reg - POOL_W'(1);
                                granted_reg  <= 1'b1;
                                aseq_reg     <= next_tag_reg;
                                next_tag_reg <= next_tag_reg + TAG_W'(1);
                            end
                        end
                        OP_RETURN:
                        begin
                            if (in_window)
                            begin
                                if (!mark_reg[seq_reg[SLOT_W-1:0]])
                                begin
                                    marks_set_reg <= marks_set_reg + CNT_W'(1);
                                end
                                mark_reg[seq_reg[SLOT_W-1:0]] <= 1'b1;
                                if (credit_reg < max_req_reg)
                                begin
                                    credit_reg <= credit_reg + REG_W'(1);
                                end
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (pool_reg < pool_cap)
                            begin
                                pool_reg <= pool_reg + POOL_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_DCHK:
                begin
                    if (status.mark_hit)
                    begin
                        mark_reg[exp_tag_reg[SLOT_W-1:0]] <= 1'b0;
                        if (marks_set_reg != '0)
                        begin
                            marks_set_reg <= marks_set_reg - CNT_W'(1);
                        end
                    end
                end
                S_DRD:
                begin
                    if (rob_rdata[CYCLE_W])
                    begin
                        if (pool_reg < pool_cap)
                        begin
                            pool_reg <= pool_reg + POOL_W'(1);
                        end
                    end
                    else if (drain_push)
                    begin
                        tail_reg     <= tail_reg + SLOT_W'(1);
                        fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(1);
                    end
                    exp_tag_reg <= exp_tag_reg + TAG_W'(1);
                end
                S_ISS2:
                begin
                    if (head_ready)
                    begin
                        ivalid_reg   <= 1'b1;
                        iseq_reg     <= fifo_rdata[TAG_W+CYCLE_W-1:CYCLE_W];
                        head_reg     <= head_reg + SLOT_W'(1);
                        fifo_cnt_reg <= fifo_cnt_reg - CNT_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, pool_reg, credit_reg, outstanding,
                                          iseq_reg, ivalid_reg, aseq_reg, granted_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// File: design/fbrd_ram.sv
`timescale 1ns / 1ps
module fbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/fbrd_seq.sv
`timescale 1ns / 1ps
module fbrd_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fbrd_pkg::seq_status_t status,
    output fbrd_pkg::state_t     state
);
    import fbrd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (status.fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.op)
                    OP_RETURN: state_next = status.in_window ? S_DCHK : S_OUT;
                    OP_ISSUE:  state_next = status.fifo_nonempty ? S_ISS2 : S_OUT;
                    default:   state_next = S_OUT;
                endcase
            end
            S_DCHK:   state_next = status.mark_hit ? S_DRD : S_OUT;
            S_DRD:    state_next = S_DCHK;
            S_ISS2:   state_next = S_OUT;
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        state = state_reg;
    end
endmodule
